@@ hw/rtl/zhe_pkg.sv @@
// Package with the item types, opcodes and table sizes of the zone evaluator.
`timescale 1ns / 1ps
package zhe_pkg;

    localparam int ZONES     = 32;
    localparam int INTERVALS = 4;
    localparam int AXES      = 2;
    localparam int LINES     = 32;

    localparam int ZW  = $clog2(ZONES);
    localparam int IW  = (INTERVALS > 1) ? $clog2(INTERVALS) : 1;
    localparam int IAW = ZW + IW;

    typedef enum logic [2:0] {
        OP_WRITE_IVL  = 3'd0,
        OP_WRITE_ZONE = 3'd1,
        OP_ARM        = 3'd2,
        OP_DISARM     = 3'd3,
        OP_EVAL       = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [5:0]         slot;
        logic [2:0]         sub_index;
        logic [4:0]         axis_or_line;
        logic [3:0]         flag_bits;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] distance_axis0;
        logic signed [31:0] distance_axis1;
        logic signed [31:0] displacement_axis0;
        logic signed [31:0] displacement_axis1;
    } item_t;

    typedef struct packed {
        logic [31:0] fired_mask;
        logic [31:0] level_line_mask;
    } result_t;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               has_lo;
        logic               has_hi;
        logic [4:0]         axis;
    } ivl_t;

    typedef struct packed {
        logic signed [31:0] wrap;
        logic signed [31:0] hyst;
        logic [2:0]         count;
        logic [4:0]         line;
        logic [3:0]         flags;
    } zone_t;

endpackage

@@ hw/rtl/zone_hysteresis_evaluator.sv @@
// Top level of the zone hysteresis evaluator.
// Channel   Direction  Handshake            Payload
// item      in         start && !busy       item (item_t)
// result    out        done, one cycle      result (result_t)
// Table writes, disarm and no-op items pass from the queue head straight to the result state.
// Arm and evaluate walk each zone in use through its intervals; a wrapped zone adds one
// modulo pass per interval, or three when a two-sided interval is missed. The serial
// modulo unit sets the worst case for an item.
// Reset clears the queue, the engaged and fire masks and the armed flag.
// The input side stalls when the two-entry queue is full; results cannot stall.
`timescale 1ns / 1ps
module zone_hysteresis_evaluator
    import zhe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    zhe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .q_valid(q_valid),
        .q_item (q_item),
        .q_pop  (q_pop)
    );

    zhe_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_valid(q_valid),
        .q_item (q_item),
        .q_pop  (q_pop),
        .done   (done),
        .result (result)
    );

endmodule

@@ hw/rtl/zhe_front.sv @@
// Input queue that accepts items and hands them to the execution engine.
`timescale 1ns / 1ps
module zhe_front
    import zhe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  item_t item,
    output logic  busy,
    output logic  q_valid,
    output item_t q_item,
    input  logic  q_pop
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_pop && q_valid;
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/zhe_mod.sv @@
// Bit-serial unit that reduces a signed value modulo a positive length.
`timescale 1ns / 1ps
module zhe_mod
    import zhe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic signed [33:0] a,
    input  logic [31:0]        p,
    output logic               done,
    output logic [31:0]        r
);

    logic [33:0] mag_reg, mag_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] p_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign done = done_reg;
    assign r    = (neg_reg && rem_reg != 32'd0) ? (p_reg - rem_reg) : rem_reg;

    always_comb
    begin
        shifted   = {rem_reg, mag_reg[33]};
        diff      = shifted - {1'b0, p_reg};
        mag_next  = {mag_reg[32:0], 1'b0};
        rem_next  = (shifted >= {1'b0, p_reg}) ? diff[31:0] : shifted[31:0];
        cnt_next  = cnt_reg - 6'd1;
        run_next  = run_reg && (cnt_reg != 6'd1);
        done_next = run_reg && (cnt_reg == 6'd1);
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            mag_reg <= a[33] ? (-a) : a;
            rem_reg <= 32'd0;
            p_reg   <= p;
            neg_reg <= a[33];
        end
        else if (run_reg)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (go)
        begin
            cnt_reg  <= 6'd34;
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= run_reg ? cnt_next : cnt_reg;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

endmodule

@@ hw/rtl/zhe_back.sv @@
// Execution engine: table writes, arming and the zone sweep over both tables.
`timescale 1ns / 1ps
module zhe_back
    import zhe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    output logic    done,
    output result_t result
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_ZRD   = 10'b0000000010,
        S_IRD   = 10'b0000000100,
        S_IVAL  = 10'b0000001000,
        S_VMOD  = 10'b0000010000,
        S_CMP   = 10'b0000100000,
        S_UMOD  = 10'b0001000000,
        S_DMOD  = 10'b0010000000,
        S_ZDONE = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    ivl_t  ivl_mem [ZONES*INTERVALS];
    zone_t zone_mem [ZONES];

    state_t      state_reg, state_next;
    item_t       cur_reg;
    zone_t       zd_reg;
    ivl_t        id_reg;
    logic [ZW:0] zi_reg;
    logic [3:0]  ji_reg;
    logic [5:0]  n_reg;
    logic        armed_reg;
    logic        is_arm_reg;
    logic [31:0] eng_reg, may_reg, fired_reg, lines_reg;
    logic signed [31:0] v_reg;
    logic [31:0] up_reg;
    logic [32:0] worst_reg;

    logic               mod_go;
    logic signed [33:0] mod_a;
    logic               mod_done;
    logic [31:0]        mod_r;
    logic               wrapped;
    logic signed [31:0] metric;
    logic               below, above;
    logic [32:0]        by_direct;
    logic [32:0]        by_min;
    logic [ZW-1:0]      zi;
    logic [5:0]         arm_n;
    logic               eng_now, eng_after;

    assign zi      = zi_reg[ZW-1:0];
    assign wrapped = (zd_reg.wrap > 0);
    assign below   = id_reg.has_lo && (v_reg < id_reg.lo);
    assign above   = id_reg.has_hi && (v_reg > id_reg.hi);
    assign by_direct = below
        ? 33'({id_reg.lo[31], id_reg.lo} - {v_reg[31], v_reg})
        : 33'({v_reg[31], v_reg} - {id_reg.hi[31], id_reg.hi});
    assign by_min  = (up_reg < mod_r) ? {1'b0, up_reg} : {1'b0, mod_r};
    assign arm_n   = (q_item.slot > 6'(ZONES)) ? 6'(ZONES) : q_item.slot;
    assign q_pop   = (state_reg == S_IDLE);
    assign done    = (state_reg == S_OUT);
    assign result.fired_mask      = fired_reg;
    assign result.level_line_mask = lines_reg;

    zhe_mod u_mod (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (mod_go),
        .a    (mod_a),
        .p    (zd_reg.wrap),
        .done (mod_done),
        .r    (mod_r)
    );

    always_comb
    begin
        metric = 32'sd0;
        if (id_reg.axis < 5'(AXES) && id_reg.axis < 5'd2)
        begin
            if (zd_reg.flags[0])
            begin
                metric = id_reg.axis[0] ? cur_reg.displacement_axis1
                                        : cur_reg.displacement_axis0;
            end
            else
            begin
                metric = id_reg.axis[0] ? cur_reg.distance_axis1 : cur_reg.distance_axis0;
            end
        end
    end

    always_comb
    begin
        mod_go = 1'b0;
        mod_a  = {{2{metric[31]}}, metric};
        case (state_reg)
            S_IVAL:
            begin
                mod_go = wrapped;
            end
            S_CMP:
            begin
                mod_go = (below || above) && wrapped && id_reg.has_lo && id_reg.has_hi;
                mod_a  = {{2{id_reg.lo[31]}}, id_reg.lo} - {{2{v_reg[31]}}, v_reg};
            end
            S_UMOD:
            begin
                mod_go = mod_done;
                mod_a  = {{2{v_reg[31]}}, v_reg} - {{2{id_reg.hi[31]}}, id_reg.hi};
            end
            default:
            begin
                mod_go = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        eng_now   = eng_reg[zi];
        eng_after = eng_now;
        if (is_arm_reg || !eng_now)
        begin
            eng_after = (worst_reg == 33'd0);
        end
        else if (worst_reg != 33'd0
                 && $signed({1'b0, worst_reg}) >= $signed({{2{zd_reg.hyst[31]}}, zd_reg.hyst}))
        begin
            eng_after = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.opcode)
                        OP_ARM:  state_next = (arm_n != 6'd0) ? S_ZRD : S_OUT;
                        OP_EVAL: state_next = (armed_reg && n_reg != 6'd0) ? S_ZRD : S_OUT;
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_ZRD:   state_next = S_IRD;
            S_IRD:   state_next = (ji_reg < {1'b0, zd_reg.count}) ? S_IVAL : S_ZDONE;
            S_IVAL:  state_next = wrapped ? S_VMOD : S_CMP;
            S_VMOD:  state_next = mod_done ? S_CMP : S_VMOD;
            S_CMP:
            begin
                if ((below || above) && wrapped && id_reg.has_lo && id_reg.has_hi)
                begin
                    state_next = S_UMOD;
                end
                else
                begin
                    state_next = S_IRD;
                end
            end
            S_UMOD:  state_next = mod_done ? S_DMOD : S_UMOD;
            S_DMOD:  state_next = mod_done ? S_IRD : S_DMOD;
            S_ZDONE: state_next = (zi_reg + 1'b1 < n_reg) ? S_ZRD : S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid && !armed_reg)
        begin
            if (q_item.opcode == OP_WRITE_IVL && q_item.slot < 6'(ZONES)
                && q_item.sub_index < 3'(INTERVALS))
            begin
                ivl_mem[{q_item.slot[ZW-1:0], q_item.sub_index[IW-1:0]}] <= '{
                    lo: q_item.value_a, hi: q_item.value_b,
                    has_lo: q_item.flag_bits[0], has_hi: q_item.flag_bits[1],
                    axis: q_item.axis_or_line};
            end
            if (q_item.opcode == OP_WRITE_ZONE && q_item.slot < 6'(ZONES))
            begin
                zone_mem[q_item.slot[ZW-1:0]] <= '{
                    wrap: q_item.value_a, hyst: q_item.value_b,
                    count: (q_item.sub_index > 3'(INTERVALS)) ? 3'(INTERVALS)
                                                               : q_item.sub_index,
                    line: q_item.axis_or_line, flags: q_item.flag_bits};
            end
        end
        if (state_reg == S_IDLE && q_valid)
        begin
            cur_reg <= q_item;
        end
        if (state_reg == S_ZRD)
        begin
            zd_reg <= zone_mem[zi];
        end
        if (state_reg == S_IRD)
        begin
            id_reg <= ivl_mem[{zi, ji_reg[IW-1:0]}];
        end
        if (state_reg == S_IVAL)
        begin
            v_reg <= metric;
        end
        if (state_reg == S_VMOD && mod_done)
        begin
            v_reg <= mod_r;
        end
        if (state_reg == S_UMOD && mod_done)
        begin
            up_reg <= mod_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            zi_reg     <= '0;
            ji_reg     <= 4'd0;
            n_reg      <= 6'd0;
            armed_reg  <= 1'b0;
            is_arm_reg <= 1'b0;
            eng_reg    <= 32'd0;
            may_reg    <= 32'd0;
            fired_reg  <= 32'd0;
            lines_reg  <= 32'd0;
            worst_reg  <= 33'd0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        fired_reg <= 32'd0;
                        zi_reg    <= '0;
                        case (q_item.opcode)
                            OP_ARM:
                            begin
                                n_reg      <= arm_n;
                                armed_reg  <= 1'b1;
                                is_arm_reg <= 1'b1;
                                eng_reg    <= 32'd0;
                                lines_reg  <= 32'd0;
                                may_reg    <= (arm_n >= 6'd32) ? 32'hFFFF_FFFF
                                              : ((32'd1 << arm_n) - 32'd1);
                            end
                            OP_DISARM:
                            begin
                                armed_reg <= 1'b0;
                                eng_reg   <= 32'd0;
                                may_reg   <= 32'd0;
                                lines_reg <= 32'd0;
                            end
                            OP_EVAL:
                            begin
                                is_arm_reg <= 1'b0;
                                if (armed_reg && n_reg != 6'd0)
                                begin
                                    lines_reg <= 32'd0;
                                end
                            end
                            default:
                            begin
                                is_arm_reg <= is_arm_reg;
                            end
                        endcase
                    end
                end
                S_ZRD:
                begin
                    ji_reg    <= 4'd0;
                    worst_reg <= 33'd0;
                end
                S_CMP:
                begin
                    if ((below || above)
                        && !(wrapped && id_reg.has_lo && id_reg.has_hi))
                    begin
                        if (by_direct > worst_reg)
                        begin
                            worst_reg <= by_direct;
                        end
                    end
                    if (state_next == S_IRD)
                    begin
                        ji_reg <= ji_reg + 4'd1;
                    end
                end
                S_DMOD:
                begin
                    if (mod_done)
                    begin
                        ji_reg <= ji_reg + 4'd1;
                        if (by_min > worst_reg)
                        begin
                            worst_reg <= by_min;
                        end
                    end
                end
                S_ZDONE:
                begin
                    eng_reg[zi] <= eng_after;
                    if (eng_after && !eng_now)
                    begin
                        if (is_arm_reg ? zd_reg.flags[1] : may_reg[zi])
                        begin
                            fired_reg[zi] <= 1'b1;
                            if (zd_reg.flags[2])
                            begin
                                may_reg[zi] <= 1'b0;
                            end
                        end
                    end
                    if (eng_after && zd_reg.flags[3] && {1'b0, zd_reg.line} < 6'(LINES))
                    begin
                        lines_reg[zd_reg.line] <= 1'b1;
                    end
                    zi_reg <= zi_reg + 1'b1;
                end
                default:
                begin
                    zi_reg <= zi_reg;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/zhe_checker.sv @@
// Port-level checks of the zone evaluator and their binding to the top level.
`timescale 1ns / 1ps
module zhe_checker
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done
);

    logic [2:0] pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_reg + {2'b0, start && !busy} - {2'b0, done};
        end
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");

    a_done_owed: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> pend_reg != 3'd0) else $error("result without an item");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd3) else $error("too many items outstanding");

    a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> pend_reg >= 3'd2) else $error("busy with room in queue");

endmodule

bind zone_hysteresis_evaluator zhe_checker u_chk (.*);

@@ sim/zone_hysteresis_evaluator_checker.sv @@
// Checker that predicts the zone evaluator results and compares them with the block.
`timescale 1ns / 1ps
module zone_hysteresis_evaluator_checker
    import zhe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   item,
    input  logic    done,
    input  result_t result,
    output int      fail_count,
    output int      pending
);

    ivl_t    ivl_tab [ZONES][INTERVALS];
    zone_t   zone_tab [ZONES];
    logic [31:0] engaged;
    logic [31:0] may_fire;
    logic    armed;
    int      in_use;
    result_t expected_q [$];

    assign pending = expected_q.size();

    function automatic longint modulo(longint v, longint p);
        longint r;
        r = v % p;
        return (r < 0) ? r + p : r;
    endfunction

    function automatic longint zone_excess(int z, item_t it);
        zone_t zn;
        ivl_t iv;
        longint worst, v, up, down, by, lo, hi;
        int n;
        logic below, above;
        zn = zone_tab[z];
        worst = 0;
        n = (zn.count > INTERVALS) ? INTERVALS : zn.count;
        for (int i = 0; i < n; i++) begin
            iv = ivl_tab[z][i];
            lo = iv.lo;
            hi = iv.hi;
            v = 0;
            if (iv.axis == 0)
                v = zn.flags[0] ? longint'(it.displacement_axis0) : longint'(it.distance_axis0);
            else if (iv.axis == 1)
                v = zn.flags[0] ? longint'(it.displacement_axis1) : longint'(it.distance_axis1);
            if (zn.wrap > 0)
                v = modulo(v, zn.wrap);
            below = iv.has_lo && (v < lo);
            above = iv.has_hi && (v > hi);
            if (below || above) begin
                if (zn.wrap > 0 && iv.has_lo && iv.has_hi) begin
                    up = modulo(lo - v, zn.wrap);
                    down = modulo(v - hi, zn.wrap);
                    by = (up < down) ? up : down;
                end
                else begin
                    by = below ? lo - v : v - hi;
                end
                if (by > worst)
                    worst = by;
            end
        end
        return worst;
    endfunction

    function automatic result_t evaluate_item(item_t it);
        result_t r;
        int n;
        longint by;
        r = '0;
        case (it.opcode)
            OP_WRITE_IVL:
                if (!armed && it.slot < ZONES && it.sub_index < INTERVALS)
                    ivl_tab[it.slot][it.sub_index] = '{lo: it.value_a, hi: it.value_b,
                        has_lo: it.flag_bits[0], has_hi: it.flag_bits[1],
                        axis: it.axis_or_line};
            OP_WRITE_ZONE:
                if (!armed && it.slot < ZONES)
                    zone_tab[it.slot] = '{wrap: it.value_a, hyst: it.value_b,
                        count: (it.sub_index > INTERVALS) ? 3'(INTERVALS) : it.sub_index,
                        line: it.axis_or_line, flags: it.flag_bits};
            OP_ARM: begin
                n = (it.slot > ZONES) ? ZONES : it.slot;
                in_use = n;
                armed = 1'b1;
                engaged = '0;
                may_fire = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
                for (int i = 0; i < n; i++) begin
                    if (zone_excess(i, it) == 0) begin
                        engaged[i] = 1'b1;
                        if (zone_tab[i].flags[1]) begin
                            r.fired_mask[i] = 1'b1;
                            if (zone_tab[i].flags[2])
                                may_fire[i] = 1'b0;
                        end
                    end
                end
            end
            OP_DISARM: begin
                armed = 1'b0;
                engaged = '0;
                may_fire = '0;
            end
            OP_EVAL:
                if (armed) begin
                    for (int i = 0; i < in_use; i++) begin
                        by = zone_excess(i, it);
                        if (!engaged[i]) begin
                            if (by == 0) begin
                                engaged[i] = 1'b1;
                                if (may_fire[i]) begin
                                    r.fired_mask[i] = 1'b1;
                                    if (zone_tab[i].flags[2])
                                        may_fire[i] = 1'b0;
                                end
                            end
                        end
                        else if (by != 0 && by >= longint'(zone_tab[i].hyst)) begin
                            engaged[i] = 1'b0;
                        end
                    end
                end
            default: ;
        endcase
        if (armed)
            for (int i = 0; i < in_use; i++)
                if (engaged[i] && zone_tab[i].flags[3])
                    r.level_line_mask[zone_tab[i].line] = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %08h expected %08h", $time, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        engaged = '0;
        may_fire = '0;
        armed = 1'b0;
        in_use = 0;
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n) begin
            if (done) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result fired_mask", result.fired_mask, '0);
                end
                else begin
                    want = expected_q.pop_front();
                    if (result.fired_mask !== want.fired_mask)
                        report_mismatch("fired_mask", result.fired_mask, want.fired_mask);
                    if (result.level_line_mask !== want.level_line_mask)
                        report_mismatch("level_line_mask", result.level_line_mask,
                                        want.level_line_mask);
                end
            end
            if (start && !busy)
                expected_q.push_back(evaluate_item(item));
        end
    end

endmodule

@@ sim/zone_hysteresis_evaluator_tb.sv @@
// Testbench top that drives items into the zone evaluator and gives the verdict.
`timescale 1ns / 1ps
module zone_hysteresis_evaluator_tb;
    import zhe_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item = '0;
    logic    busy;
    logic    done;
    result_t result;
    int      fail_count;
    int      pending;
    int      idle_cycles = 0;
    logic    calm = 1'b0;

    always #6 clk = ~clk;

    zone_hysteresis_evaluator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item),
        .busy(busy), .done(done), .result(result)
    );

    zone_hysteresis_evaluator_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 200)) - 100;
        endcase
    endfunction

    function automatic item_t rand_metrics(item_t it);
        it.distance_axis0 = rand_value();
        it.distance_axis1 = rand_value();
        it.displacement_axis0 = rand_value();
        it.displacement_axis1 = rand_value();
        return it;
    endfunction

    task automatic send(item_t it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_interval(int z, int i, int axis, int flags, int lo, int hi);
        item_t it;
        it = rand_metrics('0);
        it.opcode = OP_WRITE_IVL;
        it.slot = 6'(z);
        it.sub_index = 3'(i);
        it.axis_or_line = 5'(axis);
        it.flag_bits = 4'(flags);
        it.value_a = lo;
        it.value_b = hi;
        send(it);
    endtask

    task automatic write_zone(int z, int cnt, int line, int flags, int wrap, int hyst);
        item_t it;
        it = rand_metrics('0);
        it.opcode = OP_WRITE_ZONE;
        it.slot = 6'(z);
        it.sub_index = 3'(cnt);
        it.axis_or_line = 5'(line);
        it.flag_bits = 4'(flags);
        it.value_a = wrap;
        it.value_b = hyst;
        send(it);
    endtask

    task automatic command(opcode_t op, int n);
        item_t it;
        it = rand_metrics('0);
        it.opcode = op;
        it.slot = 6'(n);
        send(it);
    endtask

    task automatic load_table(int zones);
        for (int z = 0; z < zones; z++) begin
            for (int i = 0; i < INTERVALS; i++)
                write_interval(z, i, $urandom_range(0, 31), $urandom_range(0, 3),
                               $signed($urandom_range(0, 100)) - 60,
                               $signed($urandom_range(0, 100)) - 40);
            write_zone(z, $urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 15),
                       ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 150)) - 20 : 0,
                       $signed($urandom_range(0, 40)) - 5);
        end
    endtask

    initial
    begin
        item_t it;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every zone is written; only the first four carry intervals, all of them written.
        for (int z = 0; z < ZONES; z++) begin
            if (z < 4)
                for (int i = 0; i < INTERVALS; i++)
                    write_interval(z, i, i % 2, 3, -10, 10);
            write_zone(z, (z < 4) ? 2 : 0, z, 4'hF, 0, 5);
        end
        write_interval(0, 0, 0, 3, 32'sh8000_0000, 32'sh7FFF_FFFF);
        write_interval(1, 0, 31, 1, 5, 0);
        write_interval(40, 0, 0, 3, 0, 0);
        write_interval(2, 5, 0, 3, 0, 0);
        write_zone(2, 7, 31, 4'h7, 360, -3);
        write_zone(3, 1, 20, 4'h9, 32'sh7FFF_FFFF, 32'sh8000_0000);
        write_zone(63, 1, 0, 0, 0, 0);
        command(OP_ARM, 63);
        write_zone(0, 0, 0, 0, 0, 0);
        command(OP_EVAL, 0);
        command(OP_ARM, 4);
        command(OP_EVAL, 0);
        command(opcode_t'(3'd5), 0);
        command(opcode_t'(3'd7), 0);
        command(OP_DISARM, 0);
        command(OP_EVAL, 0);

        for (int round = 0; round < 4; round++) begin
            load_table(2);
            command(OP_ARM, (round == 3) ? 32 : $urandom_range(0, 4));
            repeat (6) begin
                it = rand_metrics('0);
                it.opcode = ($urandom_range(0, 9) == 0) ? opcode_t'($urandom_range(0, 7))
                                                         : OP_EVAL;
                it.slot = 6'($urandom_range(0, 63));
                it.sub_index = 3'($urandom_range(0, 7));
                it.axis_or_line = 5'($urandom_range(0, 31));
                it.flag_bits = 4'($urandom_range(0, 15));
                it.value_a = $urandom();
                it.value_b = $urandom();
                // Zones past the first four keep no intervals.
                if (it.opcode == OP_WRITE_ZONE && it.slot >= 6'd4)
                    it.sub_index = 3'd0;
                if (round == 3)
                    calm = 1'b1;
                send(it);
            end
            command(OP_DISARM, 0);
        end
        start <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
